// File: rtl/sss_pkg.sv
`default_nettype none
package sss_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = SAMPLE_W + ADDR_W + 1;
  localparam int PCT_W       = 7;
  localparam int DIV_W       = 45;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int DEN_W       = CNT_W;
  localparam int SQRT_STEPS  = 16;
  localparam int PT_W        = PCT_W + ADDR_W;
  localparam int PMAG_W      = 24;

  localparam logic [PCT_W-1:0]  PCT_FULL     = PCT_W'(100);
  localparam logic [PT_W-1:0]   PCT_DIVISOR  = PT_W'(100);

  // divide by 100 as multiply by ceil(2^shift / 100), exact over the operand range
  localparam logic [17:0]       PT_RECIP     = 18'd167773;
  localparam int                PT_SHIFT     = 24;
  localparam logic [PMAG_W-1:0] PMAG_RECIP   = 24'd10737419;
  localparam int                PMAG_SHIFT   = 30;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    CFG_PCT_FIRST  = 2'd0,
    CFG_PCT_SECOND = 2'd1,
    CFG_PCT_THIRD  = 2'd2
  } cfg_index_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_MEAN,
    S_MEAN_Q,
    S_VAR,
    S_SD,
    S_SD_Q,
    S_SQRT,
    S_SORT_I,
    S_SORT_V,
    S_SORT_C,
    S_SORT_W,
    S_P_T,
    S_P_Q,
    S_P_LO,
    S_P_A,
    S_P_B,
    S_P_M,
    S_P_N,
    S_P_D,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/sss_if.sv
`default_nettype none
interface sss_in_if;
  import sss_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface sss_out_if;
  import sss_pkg::*;
  logic                valid;
  logic                ready;
  sample_t             mean;
  logic [15:0]         std_dev;
  sample_t             minimum;
  sample_t             maximum;
  sample_t             pctl_first;
  sample_t             pctl_second;
  sample_t             pctl_third;
  logic [CNT_W-1:0]    samples_used;
  logic                overflowed;
  modport source (output valid, mean, std_dev, minimum, maximum, pctl_first, pctl_second,
                  pctl_third, samples_used, overflowed, input ready);
  modport sink   (input valid, mean, std_dev, minimum, maximum, pctl_first, pctl_second,
                  pctl_third, samples_used, overflowed, output ready);
endinterface
`default_nettype wire

// File: rtl/sample_set_statistics_top.sv
// Collects a set of signed Q7.8 samples, one beat per cycle, into a 1024-entry
// on-chip store and, after the beat marked last, produces one result: mean, population
// standard deviation, min, max, three interpolated percentiles, count and overflow flag.
// Samples beyond 1024 are dropped and flagged. Input is stalled after the last beat
// until the result is computed and moved to the output register: a divide for the
// mean, a squared deviation pass, a divide for the variance, a square root, an in-place
// insertion sort over the store's single read and write port (shorter on ordered
// data), then the three percentiles in turn. A serial divider of one quotient bit per
// cycle serves the mean and variance divisions; the divisions by 100 in the percentile
// step use reciprocal multiplication. The result sits in an output register so the
// next set may load while it waits to be taken.
`default_nettype none
module sample_set_statistics_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  sss_in_if.sink                    in_ch,
  sss_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [sss_pkg::PCT_W-1:0] cfg_data
);
  import sss_pkg::*;

  state_t state, state_next, div_ret;

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rdata;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  logic [PCT_W-1:0] pct [3];

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  sample_t                 run_min, run_max;
  logic                    ovf;

  logic [DIV_W-1:0]     div_quo;
  logic [DEN_W-1:0]     div_rem, div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DEN_W:0]       div_trial;

  sample_t          mean_r;
  logic [CNT_W-1:0] vk;
  logic             rd_v, prod_v;
  logic [33:0]      prod;
  logic [DIV_W-1:0] acc;
  logic signed [16:0] d_var;
  logic signed [33:0] d_sq;

  logic [31:0] sx;
  logic [32:0] sres;
  logic [30:0] sbit;
  logic [4:0]  sq_cnt;
  logic [33:0] s_try;
  logic [15:0] sd_r;

  logic [CNT_W-1:0]  si;
  logic [ADDR_W-1:0] sj;
  logic [SAMPLE_W-1:0] sv;
  logic              sort_gt;

  logic [1:0]         pi;
  logic [ADDR_W-1:0]  plo, phi, nm1;
  logic [CNT_W-1:0]   nm1_w;
  logic [PCT_W-1:0]   pr, p_eff;
  sample_t            pa;
  logic signed [24:0] pprod;
  logic signed [16:0] p_diff;
  logic signed [16:0] p_q;
  sample_t            pctl [3];
  logic [PT_W-1:0]    pt;
  logic [ADDR_W-1:0]  pq;
  logic [34:0]        pt_prod;
  logic [PMAG_W-1:0]  pmag;
  logic [47:0]        pmag_prod;
  logic [15:0]        pdq;

  logic in_fire, room, out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign room     = (count < CNT_W'(MAX_SAMPLES));
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_LOAD);

  assign nm1_w  = count - CNT_W'(1);
  assign nm1    = nm1_w[ADDR_W-1:0];
  assign phi    = (plo == nm1) ? plo : plo + ADDR_W'(1);
  assign p_eff  = (pct[pi] > PCT_FULL) ? PCT_FULL : pct[pi];
  assign div_trial = {div_rem, div_quo[DIV_W-1]};
  assign d_var  = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({mean_r[SAMPLE_W-1], mean_r});
  assign d_sq   = d_var * d_var;
  assign s_try  = 34'(sres) + 34'(sbit);
  assign sort_gt = $signed(rdata) > $signed(sv);
  assign p_diff = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({pa[SAMPLE_W-1], pa});
  assign pt_prod   = 35'(pt) * 35'(PT_RECIP);
  assign pmag_prod = 48'(pmag) * 48'(PMAG_RECIP);
  assign p_q    = pprod[24] ? -$signed({1'b0, pdq}) : $signed({1'b0, pdq});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = count[ADDR_W-1:0];
    mem_wdata  = in_ch.sample;
    mem_raddr  = '0;
    case (state)
      S_LOAD: begin
        mem_we = in_fire && room;
        if (in_fire && in_ch.last) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN:   state_next = S_DIV;
      S_MEAN_Q: state_next = S_VAR;
      S_VAR: begin
        mem_raddr = vk[ADDR_W-1:0];
        if (vk == count && !rd_v && !prod_v) begin
          state_next = S_SD;
        end
      end
      S_SD:   state_next = S_DIV;
      S_SD_Q: state_next = S_SQRT;
      S_SQRT: begin
        if (sq_cnt == 5'd1) begin
          state_next = S_SORT_I;
        end
      end
      S_SORT_I: begin
        mem_raddr = si[ADDR_W-1:0];
        state_next = (si == count) ? S_P_T : S_SORT_V;
      end
      S_SORT_V: begin
        mem_raddr  = si[ADDR_W-1:0] - ADDR_W'(1);
        state_next = S_SORT_C;
      end
      S_SORT_C: begin
        mem_we    = 1'b1;
        mem_waddr = sj;
        if (sort_gt) begin
          mem_wdata = rdata;
          mem_raddr = sj - ADDR_W'(2);
          if (sj == ADDR_W'(1)) begin
            state_next = S_SORT_W;
          end
        end else begin
          mem_wdata  = sv;
          state_next = S_SORT_I;
        end
      end
      S_SORT_W: begin
        mem_we     = 1'b1;
        mem_waddr  = sj;
        mem_wdata  = sv;
        state_next = S_SORT_I;
      end
      S_P_T: state_next = S_P_Q;
      S_P_Q: state_next = S_P_LO;
      S_P_LO: begin
        mem_raddr  = pq;
        state_next = S_P_A;
      end
      S_P_A: begin
        mem_raddr  = phi;
        state_next = S_P_B;
      end
      S_P_B: state_next = S_P_M;
      S_P_M: state_next = S_P_N;
      S_P_N: state_next = S_P_D;
      S_P_D: state_next = (pi == 2'd2) ? S_DONE : S_P_T;
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(1)) begin
          state_next = div_ret;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pct[0] <= PCT_W'(50);
      pct[1] <= PCT_W'(95);
      pct[2] <= PCT_W'(99);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PCT_FIRST:  pct[0] <= cfg_data;
        CFG_PCT_SECOND: pct[1] <= cfg_data;
        CFG_PCT_THIRD:  pct[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      sum          <= '0;
      run_min      <= '0;
      run_max      <= '0;
      ovf          <= 1'b0;
      out_ch.valid <= 1'b0;
      rd_v         <= 1'b0;
      prod_v       <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (room) begin
              count <= count + CNT_W'(1);
              sum   <= sum + SUM_W'(in_ch.sample);
              if (count == '0 || in_ch.sample < run_min) begin
                run_min <= in_ch.sample;
              end
              if (count == '0 || in_ch.sample > run_max) begin
                run_max <= in_ch.sample;
              end
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_MEAN: begin
          div_quo <= DIV_W'(sum[SUM_W-1] ? -sum : sum);
          div_den <= count;
          div_rem <= '0;
          div_cnt <= DIV_CNT_W'(DIV_W);
          div_ret <= S_MEAN_Q;
        end
        S_MEAN_Q: begin
          mean_r <= sum[SUM_W-1] ? -div_quo[SAMPLE_W-1:0] : div_quo[SAMPLE_W-1:0];
          vk     <= '0;
          acc    <= '0;
          rd_v   <= 1'b0;
          prod_v <= 1'b0;
        end
        S_VAR: begin
          if (vk != count) begin
            vk <= vk + CNT_W'(1);
          end
          rd_v   <= (vk != count);
          prod_v <= rd_v;
          prod   <= 34'(d_sq);
          if (prod_v) begin
            acc <= acc + DIV_W'(prod);
          end
        end
        S_SD: begin
          div_quo <= acc;
          div_den <= count;
          div_rem <= '0;
          div_cnt <= DIV_CNT_W'(DIV_W);
          div_ret <= S_SD_Q;
        end
        S_SD_Q: begin
          sx     <= div_quo[31:0];
          sres   <= '0;
          sbit   <= 31'(1) << 30;
          sq_cnt <= 5'(SQRT_STEPS);
        end
        S_SQRT: begin
          if (34'(sx) >= s_try) begin
            sx   <= 32'(34'(sx) - s_try);
            sres <= (sres >> 1) + 33'(sbit);
          end else begin
            sres <= sres >> 1;
          end
          sbit   <= sbit >> 2;
          sq_cnt <= sq_cnt - 5'd1;
          if (sq_cnt == 5'd1) begin
            sd_r <= (34'(sx) >= s_try) ? 16'((sres >> 1) + 33'(sbit)) : 16'(sres >> 1);
            si   <= CNT_W'(1);
            pi   <= 2'd0;
          end
        end
        S_SORT_V: begin
          sv <= rdata;
          sj <= si[ADDR_W-1:0];
        end
        S_SORT_C: begin
          if (sort_gt) begin
            sj <= sj - ADDR_W'(1);
          end else begin
            si <= si + CNT_W'(1);
          end
        end
        S_SORT_W: si <= si + CNT_W'(1);
        S_P_T: pt <= PT_W'(p_eff) * PT_W'(nm1);
        S_P_Q: pq <= pt_prod[PT_SHIFT +: ADDR_W];
        S_P_LO: begin
          plo <= pq;
          pr  <= PCT_W'(pt - PT_W'(pq) * PCT_DIVISOR);
        end
        S_P_A: pa <= rdata;
        S_P_B: pprod <= p_diff * $signed({1'b0, pr});
        S_P_M: pmag <= pprod[24] ? PMAG_W'(-pprod) : PMAG_W'(pprod);
        S_P_N: pdq <= pmag_prod[PMAG_SHIFT +: 16];
        S_P_D: begin
          pctl[pi] <= SAMPLE_W'($signed({pa[SAMPLE_W-1], pa}) + p_q);
          pi       <= pi + 2'd1;
        end
        S_DIV: begin
          if (div_trial >= {1'b0, div_den}) begin
            div_rem <= DEN_W'(div_trial - {1'b0, div_den});
            div_quo <= {div_quo[DIV_W-2:0], 1'b1};
          end else begin
            div_rem <= div_trial[DEN_W-1:0];
            div_quo <= {div_quo[DIV_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - DIV_CNT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.mean         <= mean_r;
            out_ch.std_dev      <= sd_r;
            out_ch.minimum      <= run_min;
            out_ch.maximum      <= run_max;
            out_ch.pctl_first   <= pctl[0];
            out_ch.pctl_second  <= pctl[1];
            out_ch.pctl_third   <= pctl[2];
            out_ch.samples_used <= count;
            out_ch.overflowed   <= ovf;
            count   <= '0;
            sum     <= '0;
            run_min <= '0;
            run_max <= '0;
            ovf     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/sss_checker.sv
`default_nettype none
module sss_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_last,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [15:0]                  out_minimum,
  input wire logic [15:0]                  out_maximum,
  input wire logic [sss_pkg::CNT_W-1:0]    out_samples_used
);
  import sss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken while a set is being computed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_samples_used != '0 && out_samples_used <= CNT_W'(MAX_SAMPLES))
    else $error("sample count out of range");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(out_minimum) <= $signed(out_maximum))
    else $error("minimum above maximum");

endmodule

bind sample_set_statistics_top sss_checker u_sss_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_last          (in_ch.last),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_minimum      (out_ch.minimum),
  .out_maximum      (out_ch.maximum),
  .out_samples_used (out_ch.samples_used)
);
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import sss_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    sample_t mean;
    logic [15:0] std_dev;
    sample_t minimum;
    sample_t maximum;
    sample_t pctl_first;
    sample_t pctl_second;
    sample_t pctl_third;
    logic [CNT_W-1:0] samples_used;
    logic overflowed;
  } stats_t;

  typedef struct {
    sample_t sample;
    logic last;
    logic typed;
    stats_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_PCT_FIRST;
  logic [PCT_W-1:0] cfg_data = '0;

  sss_in_if in_ch();
  sss_out_if out_ch();

  sample_set_statistics_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [PCT_W-1:0] pt_first = 7'd50, pt_second = 7'd95, pt_third = 7'd99;
  sample_t set_vals[$];
  longint set_sum;
  sample_t set_min, set_max;
  logic set_dropped;
  stats_t pending_stats[$];
  longint cycles = 0;
  bit failed = 0;
  bit calm;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sample_set_statistics_top: mismatch");
      $finish;
    end
  end

  assign calm = (cycles > 3000) && (cycles < 9000);

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 28);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, probe;
    res = '0;
    probe = 64'd1 << 62;
    while (probe > x) probe >>= 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic sample_t interp(logic [PCT_W-1:0] pt, longint srt[]);
    longint p, n, t, lo, hi, r, a, b;
    n = srt.size();
    p = (pt > 100) ? 100 : pt;
    t = p * (n - 1);
    lo = t / 100;
    r = t % 100;
    hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
    a = srt[lo];
    b = srt[hi];
    return sample_t'(a + (b - a) * r / 100);
  endfunction

  function automatic stats_t close_set();
    stats_t s;
    longint n, mean, d, v;
    longint unsigned sq, sd;
    longint srt[];
    int j;
    n = set_vals.size();
    mean = set_sum / n;
    sq = '0;
    srt = new[n];
    foreach (set_vals[i]) begin
      d = longint'(set_vals[i]) - mean;
      sq += longint'(d * d);
      v = longint'(set_vals[i]);
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    sd = int_sqrt(sq / longint'(n));
    if (sd > 65535) sd = 65535;
    s.mean = sample_t'(mean);
    s.std_dev = sd[15:0];
    s.minimum = set_min;
    s.maximum = set_max;
    s.pctl_first = interp(pt_first, srt);
    s.pctl_second = interp(pt_second, srt);
    s.pctl_third = interp(pt_third, srt);
    s.samples_used = n[CNT_W-1:0];
    s.overflowed = set_dropped;
    set_vals.delete();
    set_sum = '0;
    set_min = '0;
    set_max = '0;
    set_dropped = 1'b0;
    return s;
  endfunction

  function automatic void take_sample(sample_t x, logic last, logic typed, stats_t want);
    stats_t s;
    if (set_vals.size() < MAX_SAMPLES) begin
      if (set_vals.size() == 0 || x < set_min) set_min = x;
      if (set_vals.size() == 0 || x > set_max) set_max = x;
      set_vals.insert(set_vals.size(), x);
      set_sum += longint'(x);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      s = close_set();
      pending_stats.insert(pending_stats.size(), typed ? want : s);
    end
  endfunction

  task automatic send(sample_t x, logic last, logic typed = 1'b0,
                      stats_t want = '{default: 0});
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= x;
    in_ch.last <= last;
    @(posedge clk iff in_ch.ready);
    take_sample(x, last, typed, want);
  endtask

  task automatic write_pct(logic [1:0] idx, logic [PCT_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PCT_FIRST: pt_first = val;
      CFG_PCT_SECOND: pt_second = val;
      default: pt_third = val;
    endcase
  endtask

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      failed = 1;
      $display("%0t %s expected %0d actual %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    stats_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_stats.size() == 0) begin
        failed = 1;
        $display("%0t unexpected result beat, expected none actual mean %0d",
                 $time, out_ch.mean);
      end else begin
        e = pending_stats.pop_front();
        check_field("mean", e.mean, out_ch.mean);
        check_field("std_dev", e.std_dev, out_ch.std_dev);
        check_field("minimum", e.minimum, out_ch.minimum);
        check_field("maximum", e.maximum, out_ch.maximum);
        check_field("pctl_first", e.pctl_first, out_ch.pctl_first);
        check_field("pctl_second", e.pctl_second, out_ch.pctl_second);
        check_field("pctl_third", e.pctl_third, out_ch.pctl_third);
        check_field("samples_used", e.samples_used, out_ch.samples_used);
        check_field("overflowed", e.overflowed, out_ch.overflowed);
      end
    end
    out_ch.ready <= !idle_now();
  end

  function automatic stats_t flat(sample_t v);
    return '{v, 16'd0, v, v, v, v, v, CNT_W'(1), 1'b0};
  endfunction

  initial begin
    row_t rows[$];
    stats_t none;
    int n, mode;
    sample_t base, x;
    none = '{default: 0};
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last = 1'b0;
    set_sum = '0;
    set_min = '0;
    set_max = '0;
    set_dropped = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    rows.insert(rows.size(), row_t'{16'sh7fff, 1'b1, 1'b1, flat(16'sh7fff)});
    rows.insert(rows.size(), row_t'{-16'sh8000, 1'b1, 1'b1, flat(-16'sh8000)});
    rows.insert(rows.size(), row_t'{16'sh0000, 1'b1, 1'b1, flat(16'sh0000)});
    rows.insert(rows.size(), row_t'{-16'sh8000, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{16'sh7fff, 1'b1, 1'b0, none});
    rows.insert(rows.size(), row_t'{16'sh7fff, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{16'sh7fff, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{-16'sh8000, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{-16'sh8000, 1'b1, 1'b0, none});
    rows.insert(rows.size(), row_t'{16'sh5555, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{-16'sh5556, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{16'sh0100, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{-16'sh0001, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{16'sh0001, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{16'sh0100, 1'b1, 1'b0, none});
    foreach (rows[i]) send(rows[i].sample, rows[i].last, rows[i].typed, rows[i].want);

    write_pct(CFG_PCT_FIRST, 7'd0);
    write_pct(CFG_PCT_SECOND, 7'd100);
    write_pct(CFG_PCT_THIRD, 7'd127);
    send(16'sh0010, 1'b0);
    send(-16'sh0200, 1'b0);
    send(16'sh0300, 1'b0);
    send(16'sh0300, 1'b1);

    // store-full case on an ascending ramp so the sort stays short
    for (int i = 0; i < 1030; i++)
      send(i < MAX_SAMPLES ? sample_t'(-32768 + i * 64) : sample_t'($urandom),
           i == 1029);

    for (int k = 0; k < 65; k++) begin
      if (k % 9 == 8) begin
        write_pct(CFG_PCT_FIRST, 7'($urandom_range(127)));
        write_pct(CFG_PCT_SECOND, 7'($urandom_range(1) ? 100 : $urandom_range(127)));
        write_pct(CFG_PCT_THIRD, 7'($urandom_range(1) ? 0 : $urandom_range(127)));
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
      mode = $urandom_range(2);
      base = sample_t'($urandom);
      for (int i = 0; i < n; i++) begin
        case (mode)
          0: x = sample_t'($urandom);
          1: x = base + sample_t'($urandom_range(255)) - 16'sd128;
          default: x = $urandom_range(1) ? base : sample_t'($urandom);
        endcase
        send(x, i == n - 1);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("sample_set_statistics_top: match");
    end else begin
      $display("sample_set_statistics_top: mismatch");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/sample_set_statistics_top.sv
rtl/sss_checker.sv
test/tb.sv
